// ===== design/ci64_pkg.sv =====
// shared types and opcodes for the checked 64-bit integer alu
// no dependencies
`default_nettype none
package ci64_pkg;

  localparam int unsigned XLEN = 64;
  localparam int unsigned DIV_STAGES = XLEN;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_MOD = 4'd4,
    OP_XOR = 4'd5,
    OP_AND = 4'd6,
    OP_SHL = 4'd7,
    OP_SHR = 4'd8
  } op_t;

  // operands and partial result carried down the pipe
  typedef struct packed {
    logic [3:0]      kind;
    logic [XLEN-1:0] a;
    logic [XLEN-1:0] b;
    logic [XLEN-1:0] val;
    logic            ok;
  } side_t;

endpackage
`default_nettype wire

// ===== design/ci64_div.sv =====
// pipelined restoring divider on magnitudes, one quotient bit per stage
// depends on ci64_pkg; carries the side payload alongside
`default_nettype none
module ci64_div import ci64_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_v,
  input  wire side_t           in_side,
  input  wire logic [XLEN-1:0] in_x,
  input  wire logic [XLEN-1:0] in_y,
  output logic                 out_v,
  output side_t                out_side,
  output logic [XLEN-1:0]      out_q,
  output logic [XLEN-1:0]      out_rem
);

  logic            v_r    [DIV_STAGES+1];
  side_t           side_r [DIV_STAGES+1];
  logic [XLEN-1:0] rem_r  [DIV_STAGES+1];
  logic [XLEN-1:0] xq_r   [DIV_STAGES+1];
  logic [XLEN-1:0] y_r    [DIV_STAGES+1];
  logic [XLEN-1:0] rem_nxt [DIV_STAGES];
  logic [XLEN-1:0] xq_nxt  [DIV_STAGES];

  always_comb begin
    for (int i = 0; i < DIV_STAGES; i++) begin
      logic [XLEN:0] t;
      logic [XLEN:0] d;
      t = {rem_r[i], xq_r[i][XLEN-1]};
      d = t - {1'b0, y_r[i]};
      if (!d[XLEN]) begin
        rem_nxt[i] = d[XLEN-1:0];
        xq_nxt[i]  = {xq_r[i][XLEN-2:0], 1'b1};
      end else begin
        rem_nxt[i] = t[XLEN-1:0];
        xq_nxt[i]  = {xq_r[i][XLEN-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= DIV_STAGES; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
      for (int i = 0; i < DIV_STAGES; i++) v_r[i+1] <= v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      rem_r[0]  <= '0;
      xq_r[0]   <= in_x;
      y_r[0]    <= in_y;
      for (int i = 0; i < DIV_STAGES; i++) begin
        side_r[i+1] <= side_r[i];
        rem_r[i+1]  <= rem_nxt[i];
        xq_r[i+1]   <= xq_nxt[i];
        y_r[i+1]    <= y_r[i];
      end
    end
  end

  assign out_v    = v_r[DIV_STAGES];
  assign out_side = side_r[DIV_STAGES];
  assign out_q    = xq_r[DIV_STAGES];
  assign out_rem  = rem_r[DIV_STAGES];

endmodule
`default_nettype wire

// ===== design/checked_int64_alu.sv =====
// overflow-checked 64-bit integer alu, top level
// depends on ci64_pkg and ci64_div
//
// channel  dir  tdata                      tuser
// in_      in   [63:0] lhs, [127:64] rhs   [3:0] kind
// out_     out  [63:0] value               [0] valid_res
//
// one beat per cycle unless the output stalls; every beat runs through prep, two multiply
// stages, the 64-stage divider, final fix-up and output register
// every beat walks the same pipe, so results leave in order
// a stalled output holds the whole pipe; nothing is lost or repeated
// reset clears the valid bits only
`default_nettype none
module checked_int64_alu import ci64_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [135:0] in_tdata,  // lhs, rhs, zero pad
  input  wire logic [3:0]   in_tuser,  // kind
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [63:0]       out_tdata, // value
  output logic [0:0]        out_tuser  // valid_res
);

  localparam logic [XLEN-1:0] MIN_VAL = {1'b1, {(XLEN-1){1'b0}}};
  localparam int unsigned HALF = XLEN / 2;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // stage a: simple ops and magnitudes
  side_t           a_side_nxt, a_side_r;
  logic            a_v_r;
  logic [XLEN-1:0] a_x_nxt, a_y_nxt, a_x_r, a_y_r;

  always_comb begin
    logic [XLEN-1:0] la, lb, s, d;
    la = in_tdata[XLEN-1:0];
    lb = in_tdata[2*XLEN-1:XLEN];
    s  = la + lb;
    d  = la - lb;
    a_side_nxt.kind = in_tuser;
    a_side_nxt.a    = la;
    a_side_nxt.b    = lb;
    a_side_nxt.val  = '0;
    a_side_nxt.ok   = 1'b0;
    case (op_t'(in_tuser))
      OP_ADD: begin
        a_side_nxt.ok  = !((la[XLEN-1] ^ s[XLEN-1]) & (lb[XLEN-1] ^ s[XLEN-1]));
        a_side_nxt.val = s;
      end
      OP_SUB: begin
        a_side_nxt.ok  = !((la[XLEN-1] ^ lb[XLEN-1]) & (la[XLEN-1] ^ d[XLEN-1]));
        a_side_nxt.val = d;
      end
      OP_XOR: begin
        a_side_nxt.ok  = 1'b1;
        a_side_nxt.val = la ^ lb;
      end
      OP_AND: begin
        a_side_nxt.ok  = 1'b1;
        a_side_nxt.val = la & lb;
      end
      OP_SHL: begin
        a_side_nxt.ok  = (lb[XLEN-1:6] == '0);
        a_side_nxt.val = la << lb[5:0];
      end
      OP_SHR: begin
        a_side_nxt.ok  = (lb[XLEN-1:6] == '0);
        a_side_nxt.val = la >> lb[5:0];
      end
      default: begin
        a_side_nxt.ok  = 1'b0;
        a_side_nxt.val = '0;
      end
    endcase
    if (!a_side_nxt.ok) a_side_nxt.val = '0;
    a_x_nxt = la[XLEN-1] ? -la : la;
    a_y_nxt = lb[XLEN-1] ? -lb : lb;
  end

  // stage b: partial products
  side_t           b_side_r;
  logic            b_v_r;
  logic [XLEN-1:0] b_x_r, b_y_r;
  logic [XLEN-1:0] b_p0_r, b_p1_r, b_p2_r, b_p3_r;

  // stage c: product assembly and overflow check
  side_t           c_side_nxt, c_side_r;
  logic            c_v_r;
  logic [XLEN-1:0] c_x_r, c_y_r;

  always_comb begin
    logic [HALF+1:0] mid;
    logic [XLEN-1:0] lo, hi;
    logic            neg;
    mid = {2'b00, b_p0_r[XLEN-1:HALF]} + {2'b00, b_p1_r[HALF-1:0]}
        + {2'b00, b_p2_r[HALF-1:0]};
    lo  = {mid[HALF-1:0], b_p0_r[HALF-1:0]};
    hi  = b_p3_r + {{HALF{1'b0}}, b_p1_r[XLEN-1:HALF]}
        + {{HALF{1'b0}}, b_p2_r[XLEN-1:HALF]} + {{(XLEN-2){1'b0}}, mid[HALF+1:HALF]};
    neg = b_side_r.a[XLEN-1] ^ b_side_r.b[XLEN-1];
    c_side_nxt = b_side_r;
    if (op_t'(b_side_r.kind) == OP_MUL) begin
      if (hi != '0) begin
        c_side_nxt.ok = 1'b0;
      end else if (neg) begin
        c_side_nxt.ok = !(lo > MIN_VAL);
      end else begin
        c_side_nxt.ok = !lo[XLEN-1];
      end
      c_side_nxt.val = c_side_nxt.ok ? (neg ? -lo : lo) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_tvalid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side_r <= a_side_nxt;
      a_x_r    <= a_x_nxt;
      a_y_r    <= a_y_nxt;
      b_side_r <= a_side_r;
      b_x_r    <= a_x_r;
      b_y_r    <= a_y_r;
      b_p0_r   <= a_x_r[HALF-1:0] * a_y_r[HALF-1:0];
      b_p1_r   <= a_x_r[HALF-1:0] * a_y_r[XLEN-1:HALF];
      b_p2_r   <= a_x_r[XLEN-1:HALF] * a_y_r[HALF-1:0];
      b_p3_r   <= a_x_r[XLEN-1:HALF] * a_y_r[XLEN-1:HALF];
      c_side_r <= c_side_nxt;
      c_x_r    <= b_x_r;
      c_y_r    <= b_y_r;
    end
  end

  // divider chain
  logic            d_v;
  side_t           d_side;
  logic [XLEN-1:0] d_q, d_rem;

  ci64_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (c_v_r),
    .in_side  (c_side_r),
    .in_x     (c_x_r),
    .in_y     (c_y_r),
    .out_v    (d_v),
    .out_side (d_side),
    .out_q    (d_q),
    .out_rem  (d_rem)
  );

  // final: floor fix-up, modulo check, select
  logic [XLEN-1:0] f_val_nxt;
  logic            f_ok_nxt;

  always_comb begin
    logic            neg, nz, div_ok, fits;
    logic [XLEN-1:0] qs, rt, r;
    logic [XLEN:0]   diff;
    neg    = d_side.a[XLEN-1] ^ d_side.b[XLEN-1];
    nz     = (d_rem != '0);
    div_ok = (d_side.b != '0) && !((d_side.a == MIN_VAL) && (d_side.b == '1));
    qs     = neg ? (-d_q - {{(XLEN-1){1'b0}}, nz}) : d_q;
    rt     = d_side.a[XLEN-1] ? -d_rem : d_rem;
    r      = (neg && nz) ? (rt + d_side.b) : rt;
    diff   = {d_side.a[XLEN-1], d_side.a} - {r[XLEN-1], r};
    fits   = (diff[XLEN] == diff[XLEN-1]);
    case (op_t'(d_side.kind))
      OP_DIV: begin
        f_ok_nxt  = div_ok;
        f_val_nxt = div_ok ? qs : '0;
      end
      OP_MOD: begin
        f_ok_nxt  = div_ok && fits;
        f_val_nxt = (div_ok && fits) ? r : '0;
      end
      default: begin
        f_ok_nxt  = d_side.ok;
        f_val_nxt = d_side.val;
      end
    endcase
  end

  logic            out_v_r;
  logic [XLEN-1:0] out_val_r;
  logic            out_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_val_r <= f_val_nxt;
      out_ok_r  <= f_ok_nxt;
    end
  end

  assign out_tvalid   = out_v_r;
  assign out_tdata    = out_val_r;
  assign out_tuser[0] = out_ok_r;

endmodule
`default_nettype wire
